[design/gtss_pkg.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer package
// Sizes, shared types, register indexes and cell address helpers.
// ----------------------------------------------------------------------------
package gtss_pkg;

    localparam int TRACKS = 5;
    localparam int STEPS  = 16;
    localparam int CELLS  = TRACKS * STEPS;

    localparam int ROW_W  = $clog2(STEPS);
    localparam int COL_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    // Fixed field widths of the channels.
    localparam int IDX_W       = 7;
    localparam int TRIG_W      = 5;
    localparam int STEP_OUT_W  = 4;
    localparam int PULSE_W     = 16;
    localparam int LAST_W      = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(50);
    localparam logic [LAST_W-1:0]  LAST_RESET  = LAST_W'(15);

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_STEP    = CFG_IDX_W'(1);

    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [TRACKS-1:0]  t_rowbits;

    typedef struct packed {
        t_row row;
        t_col col;
    } t_cell;

    typedef struct packed {
        t_row fire;
        t_row tog;
        t_row view;
    } t_rd_addr;

    typedef struct packed {
        t_rowbits fire;
        t_rowbits tog;
        t_rowbits view;
    } t_rd_data;

    typedef struct packed {
        logic     en;
        t_row     row;
        t_rowbits data;
    } t_wr;

    typedef struct packed {
        logic  adv;
        logic  tog_en;
        t_row  fire_row;
        t_cell tog;
        logic  view_en;
        t_cell view;
        t_row  step;
        logic  edit;
    } t_s1;

    // Splits a grid index into its row and track without a divider.
    function automatic t_cell split_cell(input logic [IDX_W-1:0] idx);
        t_cell res;
        res = '0;
        for (int r = 0; r < STEPS; r++) begin
            if (int'(idx) >= r * TRACKS) begin
                res.row = ROW_W'(r);
                res.col = COL_W'(int'(idx) - r * TRACKS);
            end
        end
        return res;
    endfunction

    // Row sum modulo the number of steps; both operands are below STEPS.
    function automatic t_row wrap_row(input t_row a, input t_row b);
        logic [ROW_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ROW_W + 1)'(STEPS)) begin
            sum = sum - (ROW_W + 1)'(STEPS);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

[design/gtss_if.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gtss_req_if;
    logic                       valid;
    logic                       ready;
    logic                       reset_edge;
    logic                       advance_edge;
    logic                       edit_edge;
    logic                       toggle_valid;
    logic [gtss_pkg::IDX_W-1:0] toggle_index;
    logic [gtss_pkg::IDX_W-1:0] view_index;

    modport source(output valid, reset_edge, advance_edge, edit_edge, toggle_valid,
                   toggle_index, view_index, input ready);
    modport sink(input valid, reset_edge, advance_edge, edit_edge, toggle_valid,
                 toggle_index, view_index, output ready);
endinterface

interface gtss_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [gtss_pkg::TRIG_W-1:0]     trigger_bits;
    logic [gtss_pkg::STEP_OUT_W-1:0] current_step;
    logic                            edit_mode;
    logic                            view_lit;

    modport source(output valid, trigger_bits, current_step, edit_mode, view_lit,
                   input ready);
    modport sink(input valid, trigger_bits, current_step, edit_mode, view_lit,
                 output ready);
endinterface

interface gtss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gtss_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [gtss_pkg::CFG_DATA_W-1:0] wr_data;

    modport source(output valid, reg_index, wr_data, input ready);
    modport sink(input valid, reg_index, wr_data, output ready);
endinterface

[design/gtss_pattern.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer pattern store
// Two identical row memories give three registered read ports; row valid
// bits make the pattern read as cleared right after reset.
// ----------------------------------------------------------------------------
module gtss_pattern (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  gtss_pkg::t_rd_addr i_rd_addr,
    input  gtss_pkg::t_wr      i_wr,
    output gtss_pkg::t_rd_data o_rd_data
);

    gtss_pkg::t_rowbits         r_mem_a [gtss_pkg::STEPS];
    gtss_pkg::t_rowbits         r_mem_b [gtss_pkg::STEPS];
    logic [gtss_pkg::STEPS-1:0] r_row_vld;
    gtss_pkg::t_rd_data         r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr.en) begin
            r_row_vld[i_wr.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_a[i_wr.row] <= i_wr.data;
            r_mem_b[i_wr.row] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.fire <= r_row_vld[i_rd_addr.fire] ? r_mem_a[i_rd_addr.fire] : '0;
            r_rd.tog  <= r_row_vld[i_rd_addr.tog]  ? r_mem_a[i_rd_addr.tog]  : '0;
            r_rd.view <= r_row_vld[i_rd_addr.view] ? r_mem_b[i_rd_addr.view] : '0;
        end
    end

    assign o_rd_data = r_rd;

endmodule

[design/gtss_front.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer front stage
// Takes a request, updates the step row and edit mode, and issues the row
// reads for firing, toggling and viewing.
// ----------------------------------------------------------------------------
module gtss_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gtss_req_if.sink                          i_req,
    input  logic                              i_go,
    input  logic [gtss_pkg::LAST_W-1:0]       i_last_step,
    output logic                              o_rd_en,
    output gtss_pkg::t_rd_addr                o_rd_addr,
    output logic                              o_s1_valid,
    output gtss_pkg::t_s1                     o_s1
);

    gtss_pkg::t_row  r_step;
    logic            r_edit;
    logic            r_s1_valid;
    gtss_pkg::t_s1   r_s1;

    gtss_pkg::t_row  row_rst;
    gtss_pkg::t_row  last_row;
    gtss_pkg::t_row  n_step;
    logic            n_edit;
    gtss_pkg::t_cell tog_cell;
    gtss_pkg::t_cell view_cell;
    gtss_pkg::t_s1   n_s1;
    logic            accept;

    assign i_req.ready = !r_s1_valid || i_go;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        row_rst = i_req.reset_edge ? '0 : r_step;
        if (int'(i_last_step) > gtss_pkg::STEPS - 1) begin
            last_row = gtss_pkg::ROW_W'(gtss_pkg::STEPS - 1);
        end else begin
            last_row = gtss_pkg::ROW_W'(i_last_step);
        end
        n_step = row_rst;
        if (i_req.advance_edge) begin
            n_step = (row_rst < last_row) ? row_rst + gtss_pkg::ROW_W'(1) : '0;
        end
        n_edit = r_edit ^ i_req.edit_edge;

        // Outside edit mode the grid scrolls with the step row.
        tog_cell  = gtss_pkg::split_cell(i_req.toggle_index);
        view_cell = gtss_pkg::split_cell(i_req.view_index);
        if (!n_edit) begin
            tog_cell.row  = gtss_pkg::wrap_row(tog_cell.row, n_step);
            view_cell.row = gtss_pkg::wrap_row(view_cell.row, n_step);
        end

        n_s1.adv      = i_req.advance_edge;
        n_s1.tog_en   = i_req.toggle_valid && (int'(i_req.toggle_index) < gtss_pkg::CELLS);
        n_s1.fire_row = row_rst;
        n_s1.tog      = tog_cell;
        n_s1.view_en  = int'(i_req.view_index) < gtss_pkg::CELLS;
        n_s1.view     = view_cell;
        n_s1.step     = n_step;
        n_s1.edit     = n_edit;
    end

    assign o_rd_en        = accept;
    assign o_rd_addr.fire = row_rst;
    assign o_rd_addr.tog  = tog_cell.row;
    assign o_rd_addr.view = view_cell.row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_edit     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_step <= n_step;
                r_edit <= n_edit;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

[design/gtss_back.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer back stage
// Forwards the last row write, fires and counts the pulses, toggles the
// pattern cell, writes the row back and holds the response register.
// ----------------------------------------------------------------------------
module gtss_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  gtss_pkg::t_s1                 i_s1,
    input  gtss_pkg::t_rd_data            i_rd,
    input  logic [gtss_pkg::PULSE_W-1:0]  i_pulse_len,
    output logic                          o_go,
    output gtss_pkg::t_wr                 o_wr,
    gtss_rsp_if.source                    o_rsp
);

    logic [gtss_pkg::PULSE_W-1:0]    r_cnt [gtss_pkg::TRACKS];
    logic                            r_wr_v;
    gtss_pkg::t_row                  r_wr_row;
    gtss_pkg::t_rowbits              r_wr_data;
    logic                            r_o_valid;
    logic [gtss_pkg::TRIG_W-1:0]     r_trig;
    logic [gtss_pkg::STEP_OUT_W-1:0] r_step;
    logic                            r_edit;
    logic                            r_lit;

    logic [gtss_pkg::PULSE_W-1:0]    n_cnt [gtss_pkg::TRACKS];
    logic [gtss_pkg::PULSE_W-1:0]    cnt_ld;
    gtss_pkg::t_rowbits              fire_d;
    gtss_pkg::t_rowbits              tog_d;
    gtss_pkg::t_rowbits              view_d;
    gtss_pkg::t_rowbits              tog_new;
    gtss_pkg::t_rowbits              active;
    logic [gtss_pkg::TRIG_W-1:0]     trig;
    logic                            lit;
    logic                            advance;

    assign o_go    = !r_o_valid || o_rsp.ready;
    assign advance = i_s1_valid && o_go;

    always_comb begin
        // The row written by the previous request may not be in the read data yet.
        fire_d = (r_wr_v && r_wr_row == i_s1.fire_row) ? r_wr_data : i_rd.fire;
        tog_d  = (r_wr_v && r_wr_row == i_s1.tog.row)  ? r_wr_data : i_rd.tog;
        view_d = (r_wr_v && r_wr_row == i_s1.view.row) ? r_wr_data : i_rd.view;

        tog_new = tog_d;
        tog_new[i_s1.tog.col] = !tog_d[i_s1.tog.col];
        if (i_s1.tog_en && i_s1.view.row == i_s1.tog.row) begin
            view_d = tog_new;
        end
        lit = i_s1.view_en && view_d[i_s1.view.col];

        for (int t = 0; t < gtss_pkg::TRACKS; t++) begin
            cnt_ld    = (i_s1.adv && fire_d[t]) ? i_pulse_len : r_cnt[t];
            active[t] = cnt_ld != '0;
            n_cnt[t]  = cnt_ld - gtss_pkg::PULSE_W'(active[t]);
        end

        trig = '0;
        for (int t = 0; t < gtss_pkg::TRIG_W; t++) begin
            if (t < gtss_pkg::TRACKS) begin
                trig[t] = active[t];
            end
        end
    end

    assign o_wr.en   = advance && i_s1.tog_en;
    assign o_wr.row  = i_s1.tog.row;
    assign o_wr.data = tog_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_wr_v    <= 1'b0;
            for (int t = 0; t < gtss_pkg::TRACKS; t++) begin
                r_cnt[t] <= '0;
            end
        end else begin
            if (o_go) begin
                r_o_valid <= i_s1_valid;
            end
            if (advance) begin
                for (int t = 0; t < gtss_pkg::TRACKS; t++) begin
                    r_cnt[t] <= n_cnt[t];
                end
            end
            if (o_wr.en) begin
                r_wr_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_wr.en) begin
            r_wr_row  <= i_s1.tog.row;
            r_wr_data <= tog_new;
        end
        if (advance) begin
            r_trig <= trig;
            r_step <= gtss_pkg::STEP_OUT_W'(i_s1.step);
            r_edit <= i_s1.edit;
            r_lit  <= lit;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.trigger_bits = r_trig;
    assign o_rsp.current_step = r_step;
    assign o_rsp.edit_mode    = r_edit;
    assign o_rsp.view_lit     = r_lit;

endmodule

[design/grid_trigger_step_sequencer.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer
// Five-track, sixteen-step trigger sequencer with a row-organized pattern
// memory; one request and one response per tick while o_rsp is not stalled.
//
//   channel  | dir | fields
//   ---------+-----+-------------------------------------------------------
//   i_req    | in  | reset_edge advance_edge edit_edge toggle_valid
//            |     | toggle_index view_index
//   o_rsp    | out | trigger_bits current_step edit_mode view_lit
//   i_cfg    | in  | reg_index (0 pulse_length, 1 last_step) wr_data
//
// One request per cycle is sustained while o_rsp is not stalled; a
// response passes the front stage register with the pattern row reads,
// then the back stage with the read-modify-write and pulse counters, and
// sits in the output register. A stalled response holds the back stage,
// and the front stage then holds one more request. Reset is synchronous
// and clears the pattern at once through per-row valid bits, with no
// clearing pass. Register writes are always taken.
// ----------------------------------------------------------------------------
module grid_trigger_step_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtss_req_if.sink  i_req,
    gtss_rsp_if.source o_rsp,
    gtss_cfg_if.sink  i_cfg
);

    logic [gtss_pkg::PULSE_W-1:0] r_pulse_len;
    logic [gtss_pkg::LAST_W-1:0]  r_last_step;

    logic                         go;
    logic                         rd_en;
    gtss_pkg::t_rd_addr           rd_addr;
    gtss_pkg::t_rd_data           rd_data;
    gtss_pkg::t_wr                wr;
    logic                         s1_valid;
    gtss_pkg::t_s1                s1;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_len <= gtss_pkg::PULSE_RESET;
            r_last_step <= gtss_pkg::LAST_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                gtss_pkg::CFG_PULSE_LENGTH: begin
                    r_pulse_len <= i_cfg.wr_data[gtss_pkg::PULSE_W-1:0];
                end
                gtss_pkg::CFG_LAST_STEP: begin
                    r_last_step <= i_cfg.wr_data[gtss_pkg::LAST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gtss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_go        (go),
        .i_last_step (r_last_step),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1)
    );

    gtss_pattern u_pattern (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    gtss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_rd        (rd_data),
        .i_pulse_len (r_pulse_len),
        .o_go        (go),
        .o_wr        (wr),
        .o_rsp       (o_rsp)
    );

endmodule

[design/gtss_checker.sv]
// ----------------------------------------------------------------------------
// Grid trigger step sequencer checker
// Port-level properties of the sequencer, attached by bind.
// ----------------------------------------------------------------------------
module gtss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [gtss_pkg::TRIG_W-1:0]     i_rsp_trig,
    input logic [gtss_pkg::STEP_OUT_W-1:0] i_rsp_step,
    input logic                            i_rsp_edit,
    input logic                            i_rsp_lit,
    input logic                            i_cfg_valid,
    input logic                            i_cfg_ready
);

    logic req_take;

    assign req_take = i_req_valid && i_req_ready;

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable({i_rsp_trig, i_rsp_step, i_rsp_edit, i_rsp_lit}))
        else $error("response changed while stalled");

    // A response only starts after a request has passed the front and back stage registers.
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(req_take, 2))
        else $error("response without a matching request");

    // With a stalled response and a request just taken, both stages are full.
    a_req_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(req_take) && i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request taken with both stages full");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("register write not taken");

    a_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind grid_trigger_step_sequencer gtss_checker u_gtss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_trig  (o_rsp.trigger_bits),
    .i_rsp_step  (o_rsp.current_step),
    .i_rsp_edit  (o_rsp.edit_mode),
    .i_rsp_lit   (o_rsp.view_lit),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);
